>>> rtl/tpe_pkg.sv
// Shared types, codes and helpers of the trapezoid profile evaluator.
// No dependencies; imported by the evaluator top level.
`timescale 1ns / 1ps
`default_nettype none

package tpe_pkg;

	localparam int DATA_W = 32;
	localparam int SEG_W  = 2;
	localparam int REG_W  = 3;

	localparam logic [SEG_W-1:0] SEG_ACCEL  = 2'd0;
	localparam logic [SEG_W-1:0] SEG_CRUISE = 2'd1;
	localparam logic [SEG_W-1:0] SEG_DECEL  = 2'd2;
	localparam logic [SEG_W-1:0] SEG_DONE   = 2'd3;

	localparam logic [REG_W-1:0] REG_ACCEL_END_TIME   = 3'd0;
	localparam logic [REG_W-1:0] REG_DECEL_START_TIME = 3'd1;
	localparam logic [REG_W-1:0] REG_TOTAL_TIME       = 3'd2;
	localparam logic [REG_W-1:0] REG_ACCEL_RATE       = 3'd3;
	localparam logic [REG_W-1:0] REG_DECEL_RATE       = 3'd4;
	localparam logic [REG_W-1:0] REG_START_VELOCITY   = 3'd5;
	localparam logic [REG_W-1:0] REG_CRUISE_VELOCITY  = 3'd6;
	localparam logic [REG_W-1:0] REG_DISTANCE         = 3'd7;

	// What a word in the pipeline computes: a sample, or one of the derived values
	typedef enum logic [1:0] {
		KIND_ITEM,
		KIND_CSP,
		KIND_DSP,
		KIND_FIN
	} kind_t;

	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
		logic [DATA_W-1:0] r;
		r = x[DATA_W-1] ? (~x + 32'd1) : x;
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/trapezoid_profile_evaluator.sv
// Trapezoid profile evaluator top level: six-stage fixed point pipeline.
// Depends on tpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One sample_time word is taken per cycle (start high while busy is low); its
// position, velocity, acceleration and segment appear on the result ports with
// done high for one cycle, once the word has passed the six register stages.
// The receiver cannot stall, and the pipeline keeps taking a new word every
// cycle while busy is low. The six register stages are segment select, the
// 32x32 products, the split 64x32 product of the quadratic term, partial product
// merge, term sum and the saturating output stage. After each configuration
// write, busy is high while the cruise start position, decel start position
// and final speed are computed by three words sent through the same pipeline.
module trapezoid_profile_evaluator #(
	parameter int FRAC_BITS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [tpe_pkg::DATA_W-1:0]          sample_time,
	output logic                                done,
	output logic signed [tpe_pkg::DATA_W-1:0]   position,
	output logic signed [tpe_pkg::DATA_W-1:0]   velocity,
	output logic signed [tpe_pkg::DATA_W-1:0]   acceleration,
	output logic [tpe_pkg::SEG_W-1:0]           segment,
	input  wire                                 cfg_we,
	input  wire  [tpe_pkg::REG_W-1:0]           cfg_index,
	input  wire  [tpe_pkg::DATA_W-1:0]          cfg_data
);
	import tpe_pkg::*;

	localparam int NSTG    = 6;
	localparam int SEQ_B   = NSTG;
	localparam int SEQ_END = 2 * NSTG - 1;
	localparam int SEQ_W   = $clog2(SEQ_END + 1);
	localparam int TW      = 64 - FRAC_BITS;
	localparam int SW      = TW + 2;
	localparam int QSH     = 2 * FRAC_BITS + 1;
	localparam int QLIM    = QSH + 62;

	// Configuration and derived state
	logic [DATA_W-1:0]        tc_q, tl_q, tf_q;
	logic signed [DATA_W-1:0] a1_q, a2_q, v0_q, vc_q, dist_q;
	logic signed [DATA_W-1:0] csp_q, dsp_q, final_q;
	logic                     run_q;
	logic [SEQ_W-1:0]         seq_q;

	logic accept, inj_a, inj_b, inj_c;

	assign busy   = run_q;
	assign accept = start && !run_q;
	assign inj_a  = run_q && (seq_q == SEQ_W'(0));
	assign inj_c  = run_q && (seq_q == SEQ_W'(1));
	assign inj_b  = run_q && (seq_q == SEQ_W'(SEQ_B));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q   <= '0;
			tl_q   <= '0;
			tf_q   <= '0;
			a1_q   <= '0;
			a2_q   <= '0;
			v0_q   <= '0;
			vc_q   <= '0;
			dist_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEL_END_TIME:   tc_q   <= cfg_data;
				REG_DECEL_START_TIME: tl_q   <= cfg_data;
				REG_TOTAL_TIME:       tf_q   <= cfg_data;
				REG_ACCEL_RATE:       a1_q   <= $signed(cfg_data);
				REG_DECEL_RATE:       a2_q   <= $signed(cfg_data);
				REG_START_VELOCITY:   v0_q   <= $signed(cfg_data);
				REG_CRUISE_VELOCITY:  vc_q   <= $signed(cfg_data);
				REG_DISTANCE:         dist_q <= $signed(cfg_data);
			endcase
		end
	end

	// Restart the derivation on every write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			seq_q <= '0;
		end else if (cfg_we) begin
			run_q <= 1'b1;
			seq_q <= '0;
		end else if (run_q) begin
			if (seq_q == SEQ_W'(SEQ_END)) begin
				run_q <= 1'b0;
			end
			seq_q <= seq_q + SEQ_W'(1);
		end
	end

	// ---------------- stage 1: segment and operand select ----------------
	logic [DATA_W-1:0]        dc, dl, span1, span2;
	logic                     lt_c, lt_l, le_f;
	logic                     valid_n, vneg_n, aneg_n;
	kind_t                    kind_n;
	logic [SEG_W-1:0]         seg_n;
	logic [DATA_W-1:0]        d_n, vmag_n, amag_n;
	logic signed [DATA_W-1:0] v_n, x0_n, acc_n;

	assign lt_c  = sample_time < tc_q;
	assign lt_l  = sample_time < tl_q;
	assign le_f  = sample_time <= tf_q;
	assign dc    = sample_time - tc_q;
	assign dl    = sample_time - tl_q;
	assign span1 = (tl_q > tc_q) ? (tl_q - tc_q) : '0;
	assign span2 = (tf_q > tl_q) ? (tf_q - tl_q) : '0;

	always_comb begin
		valid_n = 1'b0;
		kind_n  = KIND_ITEM;
		seg_n   = SEG_DONE;
		d_n     = dl;
		v_n     = vc_q;
		vmag_n  = mag32(vc_q);
		vneg_n  = vc_q[DATA_W-1];
		amag_n  = mag32(a2_q);
		aneg_n  = a2_q[DATA_W-1];
		x0_n    = '0;
		acc_n   = a2_q;
		priority if (inj_a) begin
			valid_n = 1'b1;
			kind_n  = KIND_CSP;
			d_n     = tc_q;
			v_n     = v0_q;
			vmag_n  = mag32(v0_q);
			vneg_n  = v0_q[DATA_W-1];
			amag_n  = mag32(a1_q);
			aneg_n  = a1_q[DATA_W-1];
		end else if (inj_c) begin
			valid_n = 1'b1;
			kind_n  = KIND_FIN;
			d_n     = span2;
		end else if (inj_b) begin
			valid_n = 1'b1;
			kind_n  = KIND_DSP;
			d_n     = span1;
			amag_n  = '0;
			aneg_n  = 1'b0;
			x0_n    = csp_q;
		end else if (accept) begin
			valid_n = 1'b1;
			priority if (lt_c) begin
				seg_n  = SEG_ACCEL;
				d_n    = sample_time;
				v_n    = v0_q;
				vmag_n = mag32(v0_q);
				vneg_n = v0_q[DATA_W-1];
				amag_n = mag32(a1_q);
				aneg_n = a1_q[DATA_W-1];
				acc_n  = a1_q;
			end else if (lt_l) begin
				seg_n  = SEG_CRUISE;
				d_n    = dc;
				amag_n = '0;
				aneg_n = 1'b0;
				x0_n   = csp_q;
				acc_n  = '0;
			end else if (le_f) begin
				seg_n  = SEG_DECEL;
				x0_n   = dsp_q;
			end else begin
				seg_n  = SEG_DONE;
			end
		end else begin
			// Idle cycle: no word enters
			valid_n = 1'b0;
		end
	end

	logic                     valid_s1, vneg_s1, aneg_s1;
	kind_t                    kind_s1;
	logic [SEG_W-1:0]         seg_s1;
	logic [DATA_W-1:0]        d_s1, vmag_s1, amag_s1;
	logic signed [DATA_W-1:0] v_s1, x0_s1, acc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_n;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind_n;
		seg_s1  <= seg_n;
		d_s1    <= d_n;
		v_s1    <= v_n;
		vmag_s1 <= vmag_n;
		vneg_s1 <= vneg_n;
		amag_s1 <= amag_n;
		aneg_s1 <= aneg_n;
		x0_s1   <= x0_n;
		acc_s1  <= acc_n;
	end

	// ---------------- stage 2: |a|*d and |v|*d ----------------
	logic [63:0] p_ad, p_vd;

	assign p_ad = amag_s1 * d_s1;
	assign p_vd = vmag_s1 * d_s1;

	logic                     valid_s2, vneg_s2, aneg_s2;
	kind_t                    kind_s2;
	logic [SEG_W-1:0]         seg_s2;
	logic [DATA_W-1:0]        d_s2;
	logic [63:0]              p_ad_s2, p_vd_s2;
	logic signed [DATA_W-1:0] v_s2, x0_s2, acc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		seg_s2  <= seg_s1;
		d_s2    <= d_s1;
		p_ad_s2 <= p_ad;
		p_vd_s2 <= p_vd;
		v_s2    <= v_s1;
		vneg_s2 <= vneg_s1;
		aneg_s2 <= aneg_s1;
		x0_s2   <= x0_s1;
		acc_s2  <= acc_s1;
	end

	// ---------------- stage 3: quadratic partials, linear sums ----------------
	logic [63:0]          pp_lo, pp_hi;
	logic [SW-1:0]        vterm, lterm;
	logic signed [SW-1:0] vel_sum, lin_sum;

	assign pp_lo = p_ad_s2[31:0] * d_s2;
	assign pp_hi = p_ad_s2[63:32] * d_s2;
	assign vterm = {2'b00, p_ad_s2[63:FRAC_BITS]};
	assign lterm = {2'b00, p_vd_s2[63:FRAC_BITS]};
	// Signed term as magnitude xor sign plus sign, folded into one add
	assign vel_sum = $signed({{(SW-DATA_W){v_s2[DATA_W-1]}}, v_s2})
		+ $signed(vterm ^ {SW{aneg_s2}}) + $signed({{(SW-1){1'b0}}, aneg_s2});
	assign lin_sum = $signed({{(SW-DATA_W){x0_s2[DATA_W-1]}}, x0_s2})
		+ $signed(lterm ^ {SW{vneg_s2}}) + $signed({{(SW-1){1'b0}}, vneg_s2});

	logic                     valid_s3, aneg_s3;
	kind_t                    kind_s3;
	logic [SEG_W-1:0]         seg_s3;
	logic [63:0]              pp_lo_s3, pp_hi_s3;
	logic signed [SW-1:0]     vel_sum_s3, lin_sum_s3;
	logic signed [DATA_W-1:0] acc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		kind_s3    <= kind_s2;
		seg_s3     <= seg_s2;
		pp_lo_s3   <= pp_lo;
		pp_hi_s3   <= pp_hi;
		vel_sum_s3 <= vel_sum;
		lin_sum_s3 <= lin_sum;
		aneg_s3    <= aneg_s2;
		acc_s3     <= acc_s2;
	end

	// ---------------- stage 4: merge partials, saturate velocity ----------------
	logic [95:0] prod;

	assign prod = {32'd0, pp_lo_s3} + {pp_hi_s3, 32'd0};

	logic                     valid_s4, aneg_s4;
	kind_t                    kind_s4;
	logic [SEG_W-1:0]         seg_s4;
	logic [95:0]              prod_s4;
	logic signed [SW-1:0]     lin_sum_s4;
	logic signed [DATA_W-1:0] vel_s4, acc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		kind_s4    <= kind_s3;
		seg_s4     <= seg_s3;
		prod_s4    <= prod;
		lin_sum_s4 <= lin_sum_s3;
		vel_s4     <= sat32({{(64-SW){vel_sum_s3[SW-1]}}, vel_sum_s3});
		aneg_s4    <= aneg_s3;
		acc_s4     <= acc_s3;
	end

	// ---------------- stage 5: limit quadratic term, sum position ----------------
	logic [127:0]       prod_ext;
	logic               q_ovf;
	logic [62:0]        qc;
	logic signed [63:0] pos_sum;

	assign prod_ext = {32'd0, prod_s4};
	assign q_ovf    = |prod_ext[127:QLIM];
	assign qc       = q_ovf ? {1'b1, 62'd0} : {1'b0, prod_ext[QLIM-1:QSH]};
	assign pos_sum  = $signed({{(64-SW){lin_sum_s4[SW-1]}}, lin_sum_s4})
		+ $signed({1'b0, qc} ^ {64{aneg_s4}}) + $signed({63'd0, aneg_s4});

	logic                     valid_s5;
	kind_t                    kind_s5;
	logic [SEG_W-1:0]         seg_s5;
	logic signed [63:0]       pos_sum_s5;
	logic signed [DATA_W-1:0] vel_s5, acc_s5, pos_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		kind_s5    <= kind_s4;
		seg_s5     <= seg_s4;
		pos_sum_s5 <= pos_sum;
		vel_s5     <= vel_s4;
		acc_s5     <= acc_s4;
	end

	assign pos_sat = sat32(pos_sum_s5);

	// ---------------- stage 6: output word and derived state ----------------
	logic                     done_s6;
	logic signed [DATA_W-1:0] pos_s6, vel_s6, acc_s6;
	logic [SEG_W-1:0]         seg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
			csp_q   <= '0;
			dsp_q   <= '0;
			final_q <= '0;
		end else begin
			done_s6 <= valid_s5 && (kind_s5 == KIND_ITEM);
			if (valid_s5) begin
				unique case (kind_s5)
					KIND_CSP:  csp_q   <= pos_sat;
					KIND_DSP:  dsp_q   <= pos_sat;
					KIND_FIN:  final_q <= vel_s5;
					KIND_ITEM: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		// After the end, hold the full distance and the final speed
		pos_s6 <= (seg_s5 == SEG_DONE) ? dist_q : pos_sat;
		vel_s6 <= (seg_s5 == SEG_DONE) ? final_q : vel_s5;
		acc_s6 <= acc_s5;
		seg_s6 <= seg_s5;
	end

	assign done         = done_s6;
	assign position     = pos_s6;
	assign velocity     = vel_s6;
	assign acceleration = acc_s6;
	assign segment      = seg_s6;

endmodule

`default_nettype wire
